// ===== rtl/core/grid_local_maximum_finder_assert.svh =====
// Assertion macros shared by the grid local maximum finder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GRID_LOCAL_MAXIMUM_FINDER_ASSERT_SVH
`define GRID_LOCAL_MAXIMUM_FINDER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, held off while reset is asserted.
`define GLMF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked property, also evaluated during reset.
`define GLMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GLMF_ASSERT(lbl, clk, rstn, prop, msg)
`define GLMF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/glmf_pkg.sv =====
// Shared types and constants of the grid local maximum finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package glmf_pkg;

    localparam int VALUE_W     = 32;
    localparam int IDX_W       = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    // Results one cell can cause, and the result queue that absorbs them
    localparam int GROUP_MAX  = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // One line store entry: value plus "not below the cell above it"
    typedef struct packed {
        logic               up_ok;
        logic [VALUE_W-1:0] value;
    } cell_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] column;
        logic             last;
    } peak_t;

    // Results of one transfer, packed into slots 0..count-1 in raster order
    typedef struct packed {
        logic [1:0]              count;
        peak_t [GROUP_MAX-1:0]   slot;
    } res_group_t;

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_W-1:0]       data;
    } cfg_write_t;

endpackage

// ===== rtl/core/grid_local_maximum_finder.sv =====
// Top level of the grid local maximum finder (4-neighbor peaks on a raster stream).
// Depends on glmf_pkg, glmf_scan_core, glmf_line_store and glmf_result_fifo.
//
// Usage:
//   Program row_count (index 0) and column_count (index 1) on the cfg port while
//   idle; any such write restarts the frame at row 0, column 0. Cells then enter
//   in raster order on the s_ channel (valid/ready), one per cycle at full rate.
//   Each peak comes out on the m_ channel as row and column, with last_of_run on
//   the final result caused by one input cell. Results are in raster order.
//   A result enters the result queue at the deciding cell's transfer and is
//   offered on m_ from there. Throughput: one cell per cycle while the m_ side
//   keeps up; a cell yields zero to three results and the m_ side drains one
//   per cycle, so the output port sets the sustained rate on peak-dense frames.
//   An eight-entry result queue sits between the sides; s_ready drops while it
//   holds more than five results, so a stalled receiver stalls the input.
//   Line history is a single store of MAX_COLUMNS entries; no clearing pass.
//   Reset: counts return to 1, position to the frame start, the queue empties.
`timescale 1ns / 1ps

module grid_local_maximum_finder #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [glmf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [glmf_pkg::CFG_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [glmf_pkg::VALUE_W-1:0]   s_cell_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [glmf_pkg::IDX_W-1:0]            m_peak_row,
    output logic [glmf_pkg::IDX_W-1:0]            m_peak_column,
    output logic                                  m_last_of_run
);
    import glmf_pkg::*;

    cfg_write_t cfg;
    res_group_t group;
    peak_t      out_peak;
    logic       room;
    logic       accept;

    assign cfg    = '{en: cfg_wr_en, index: cfg_index, data: cfg_wr_data};
    assign accept = s_valid && room;

    glmf_scan_core #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_scan_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .cell_value (s_cell_value),
        .group      (group)
    );

    glmf_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .group     (group),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_peak  (out_peak)
    );

    assign s_ready       = room;
    assign m_peak_row    = out_peak.row;
    assign m_peak_column = out_peak.column;
    assign m_last_of_run = out_peak.last;

endmodule

// ===== rtl/core/glmf_line_store.sv =====
// Single line store: one write port, one registered read port.
// Depends on glmf_pkg for the entry type.
`timescale 1ns / 1ps

module glmf_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  glmf_pkg::cell_t          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output glmf_pkg::cell_t          rd_data
);
    import glmf_pkg::*;

    cell_t mem [DEPTH];
    cell_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/glmf_scan_core.sv =====
// Raster position tracking, previous-row window and the peak decisions.
// Depends on glmf_pkg, glmf_line_store and the assertion macro header.
`timescale 1ns / 1ps
`include "grid_local_maximum_finder_assert.svh"

module glmf_scan_core #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  glmf_pkg::cfg_write_t                cfg,
    input  logic                                accept,
    input  logic signed [glmf_pkg::VALUE_W-1:0] cell_value,
    output glmf_pkg::res_group_t                group
);
    import glmf_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CPW = $clog2(MAX_COLUMNS);
    localparam int RCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
    localparam int CCW = (CPW + 1 > CFG_W) ? CPW + 1 : CFG_W;

    logic [CFG_W-1:0] row_count_reg, column_count_reg;
    logic [RW-1:0]    row_pos_reg;
    logic [CPW-1:0]   col_pos_reg;
    logic             use_first_reg;

    // Window on the previous row around the current column
    logic [VALUE_W-1:0] p0_reg;
    cell_t              p1_reg;
    cell_t              first0_reg, first1_reg;
    // Last two cells of the current row
    cell_t              cur_m1_reg;
    logic [VALUE_W-1:0] cur_m2_reg;

    cell_t              rd_data, p2, x_cell;
    logic [RCW-1:0]     rows_raw, rows_eff;
    logic [CCW-1:0]     cols_raw, cols_eff;
    logic               first_row, first_col, last_row, last_col, col_ge2, rd_en;
    logic               x_up_ok, hit_a, hit_b, hit_c;
    logic [RW-1:0]      row_above;
    logic [CPW-1:0]     col_left;
    peak_t              peak_a, peak_b, peak_c;

    always_comb begin
        rows_raw = RCW'(row_count_reg);
        cols_raw = CCW'(column_count_reg);
        if (rows_raw == '0) begin
            rows_eff = RCW'(1);
        end else if (rows_raw > RCW'(MAX_ROWS)) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = rows_raw;
        end
        if (cols_raw == '0) begin
            cols_eff = CCW'(1);
        end else if (cols_raw > CCW'(MAX_COLUMNS)) begin
            cols_eff = CCW'(MAX_COLUMNS);
        end else begin
            cols_eff = cols_raw;
        end
    end

    assign first_row = (row_pos_reg == '0);
    assign first_col = (col_pos_reg == '0);
    assign last_row  = (RCW'(row_pos_reg) == rows_eff - RCW'(1));
    assign last_col  = (CCW'(col_pos_reg) == cols_eff - CCW'(1));
    assign col_ge2   = (CCW'(col_pos_reg) >= CCW'(2));
    assign row_above = row_pos_reg - RW'(1);
    assign col_left  = col_pos_reg - CPW'(1);

    // At the start of a row the first two columns come from capture registers
    assign p2 = use_first_reg ? first1_reg : rd_data;

    always_comb begin
        x_up_ok = first_row || ($signed(cell_value) >= $signed(p1_reg.value));
        x_cell  = '{up_ok: x_up_ok, value: cell_value};

        // Cell above: its lower neighbor is this transfer
        hit_a = !first_row && p1_reg.up_ok
                && ($signed(p1_reg.value) >= $signed(cell_value))
                && (first_col || ($signed(p1_reg.value) >= $signed(p0_reg)))
                && (last_col || ($signed(p1_reg.value) >= $signed(p2.value)));
        // Left cell in the last row: its right neighbor is this transfer
        hit_b = last_row && !first_col && cur_m1_reg.up_ok
                && ($signed(cur_m1_reg.value) >= $signed(cell_value))
                && (!col_ge2 || ($signed(cur_m1_reg.value) >= $signed(cur_m2_reg)));
        // Final cell of the frame
        hit_c = last_row && last_col && x_up_ok
                && (first_col || ($signed(cell_value) >= $signed(cur_m1_reg.value)));

        peak_a = '{row: IDX_W'(row_above), column: IDX_W'(col_pos_reg),
                   last: !hit_b && !hit_c};
        peak_b = '{row: IDX_W'(row_pos_reg), column: IDX_W'(col_left), last: !hit_c};
        peak_c = '{row: IDX_W'(row_pos_reg), column: IDX_W'(col_pos_reg), last: 1'b1};

        group.count = accept ? ({1'b0, hit_a} + {1'b0, hit_b} + {1'b0, hit_c}) : 2'd0;
        group.slot[0] = hit_a ? peak_a : (hit_b ? peak_b : peak_c);
        group.slot[1] = (hit_a && hit_b) ? peak_b : peak_c;
        group.slot[2] = peak_c;
    end

    assign rd_en = accept && (CCW'(col_pos_reg) + CCW'(2) < cols_eff);

    glmf_line_store #(
        .DEPTH(MAX_COLUMNS)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_pos_reg),
        .wr_data (x_cell),
        .rd_en   (rd_en),
        .rd_addr (col_pos_reg + CPW'(2)),
        .rd_data (rd_data)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= CFG_W'(1);
            column_count_reg <= CFG_W'(1);
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            use_first_reg    <= 1'b0;
        end else if (cfg.en) begin
            unique case (cfg.index)
                REG_ROW_COUNT: begin
                    row_count_reg <= cfg.data;
                    row_pos_reg   <= '0;
                    col_pos_reg   <= '0;
                end
                REG_COLUMN_COUNT: begin
                    column_count_reg <= cfg.data;
                    row_pos_reg      <= '0;
                    col_pos_reg      <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            use_first_reg <= last_col;
            if (last_col) begin
                col_pos_reg <= '0;
                row_pos_reg <= last_row ? '0 : row_pos_reg + RW'(1);
            end else begin
                col_pos_reg <= col_pos_reg + CPW'(1);
            end
        end
    end

    // Window and row history
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_m1_reg <= x_cell;
            cur_m2_reg <= cur_m1_reg.value;
            if (first_col) begin
                first0_reg <= x_cell;
            end
            if (CCW'(col_pos_reg) == CCW'(1)) begin
                first1_reg <= x_cell;
            end
            if (last_col) begin
                p1_reg <= first_col ? x_cell : first0_reg;
            end else begin
                p0_reg <= p1_reg.value;
                p1_reg <= p2;
            end
        end
    end

    `GLMF_ASSERT(a_col_in_range, aclk, aresetn, CCW'(col_pos_reg) < cols_eff, "column position out of range")
    `GLMF_ASSERT(a_row_in_range, aclk, aresetn, RCW'(row_pos_reg) < rows_eff, "row position out of range")

endmodule

// ===== rtl/core/glmf_result_fifo.sv =====
// Result queue: takes up to three results per cycle, hands out one per transfer.
// Depends on glmf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "grid_local_maximum_finder_assert.svh"

module glmf_result_fifo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  glmf_pkg::res_group_t       group,
    output logic                       room,
    output logic                       out_valid,
    input  logic                       out_ready,
    output glmf_pkg::peak_t            out_peak
);
    import glmf_pkg::*;

    peak_t                 entry_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_peak  = entry_mem[rd_ptr_reg];
    // Room for a worst-case group, from registered state only
    assign room      = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - GROUP_MAX));
    assign cnt_next  = cnt_reg + FIFO_CNT_W'(group.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(group.count);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(pop);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < GROUP_MAX; k++) begin
            if (k < int'(group.count)) begin
                entry_mem[wr_ptr_reg + FIFO_PTR_W'(k)] <= group.slot[k];
            end
        end
    end

    `GLMF_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
    `GLMF_ASSERT(a_push_room, aclk, aresetn, (group.count != 2'd0) |-> room, "results pushed without room")

endmodule

// ===== tb/glmf_peak_checker.sv =====
// Peak checker for the grid local maximum finder: predicts every result from the
// cfg writes and s_ transfers it observes and compares the m_ transfers in order.
// Depends on glmf_pkg.
`timescale 1ns / 1ps

module glmf_peak_checker #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [glmf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [glmf_pkg::CFG_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic signed [glmf_pkg::VALUE_W-1:0]   s_cell_value,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [glmf_pkg::IDX_W-1:0]            m_peak_row,
    input  logic [glmf_pkg::IDX_W-1:0]            m_peak_column,
    input  logic                                  m_last_of_run,
    output int                                    fail_count,
    output int                                    pending
);
    import glmf_pkg::*;

    // Two row histories that swap roles at every row end
    logic signed [VALUE_W-1:0] bank0_line [MAX_COLUMNS];
    logic signed [VALUE_W-1:0] bank1_line [MAX_COLUMNS];
    bit                        flip;
    logic [CFG_W-1:0]          row_reg;
    logic [CFG_W-1:0]          col_reg;
    int unsigned               row_at;
    int unsigned               col_at;
    peak_t                     expected_peaks [$];
    int                        mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic signed [VALUE_W-1:0] prev_cell(input int unsigned i);
        return flip ? bank0_line[i] : bank1_line[i];
    endfunction

    function automatic logic signed [VALUE_W-1:0] work_cell(input int unsigned i);
        return flip ? bank1_line[i] : bank0_line[i];
    endfunction

    function automatic int unsigned clamp_count(input logic [CFG_W-1:0] raw,
                                                input int unsigned top);
        if (raw == 0) return 1;
        if (raw > top) return top;
        return raw;
    endfunction

    function automatic peak_t peak_at(input int unsigned r, input int unsigned c);
        peak_t p;
        p.row    = IDX_W'(r);
        p.column = IDX_W'(c);
        p.last   = 1'b0;
        return p;
    endfunction

    task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_W-1:0] data);
        if (idx == REG_ROW_COUNT) row_reg = data;
        else if (idx == REG_COLUMN_COUNT) col_reg = data;
        else return;
        // any mapped write restarts the frame; the line banks keep their roles
        row_at = 0;
        col_at = 0;
    endtask

    task automatic predict_cell(input logic signed [VALUE_W-1:0] x);
        int unsigned               rows;
        int unsigned               cols;
        int unsigned               r;
        int unsigned               c;
        logic signed [VALUE_W-1:0] v;
        bit                        ok;
        peak_t                     found [$];
        rows = clamp_count(row_reg, MAX_ROWS);
        cols = clamp_count(col_reg, MAX_COLUMNS);
        r = row_at;
        c = col_at;
        if (r >= rows || c >= cols) begin
            r = 0;
            c = 0;
        end

        // cell above is decided now that its lower neighbor is here
        if (r >= 1) begin
            v  = prev_cell(c);
            ok = v >= x;
            if (r >= 2) ok = ok && v >= work_cell(c);
            if (c >= 1) ok = ok && v >= prev_cell(c - 1);
            if (c + 1 < cols) ok = ok && v >= prev_cell(c + 1);
            if (ok) found.push_back(peak_at(r - 1, c));
        end

        if (flip) bank1_line[c] = x;
        else bank0_line[c] = x;

        if (r == rows - 1) begin
            // last row: left neighbor has no cell below, so decide it here
            if (c >= 1) begin
                v  = work_cell(c - 1);
                ok = v >= x;
                if (r >= 1) ok = ok && v >= prev_cell(c - 1);
                if (c >= 2) ok = ok && v >= work_cell(c - 2);
                if (ok) found.push_back(peak_at(r, c - 1));
            end
            if (c == cols - 1) begin
                ok = 1'b1;
                if (r >= 1) ok = ok && x >= prev_cell(c);
                if (c >= 1) ok = ok && x >= work_cell(c - 1);
                if (ok) found.push_back(peak_at(r, c));
            end
        end

        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[k]) expected_peaks.push_back(found[k]);

        c++;
        if (c >= cols) begin
            c = 0;
            flip = !flip;
            r++;
            if (r >= rows) r = 0;
        end
        row_at = r;
        col_at = c;
    endtask

    task automatic check_peak();
        peak_t want;
        if (expected_peaks.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: peak row %0d col %0d last %0b arrived with none pending",
                         $realtime, m_peak_row, m_peak_column, m_last_of_run);
            mismatches++;
            return;
        end
        want = expected_peaks.pop_front();
        if (want.row !== m_peak_row || want.column !== m_peak_column ||
            want.last !== m_last_of_run) begin
            if (mismatches < 10)
                $display("%0t: expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
                         $realtime, want.row, want.column, want.last,
                         m_peak_row, m_peak_column, m_last_of_run);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_peaks.delete();
            flip    = 1'b0;
            row_reg = CFG_W'(1);
            col_reg = CFG_W'(1);
            row_at  = 0;
            col_at  = 0;
        end else begin
            if (cfg_wr_en) apply_write(cfg_index, cfg_wr_data);
            // results leaving now were queued before this edge's input transfer
            if (m_valid && m_ready) check_peak();
            if (s_valid && s_ready) predict_cell(s_cell_value);
        end
        pending = expected_peaks.size();
    end

endmodule

// ===== tb/grid_local_maximum_finder_tb.sv =====
// Top of the grid local maximum finder testbench: clock, reset, cfg writes, cell
// stimulus and result-side backpressure. Depends on glmf_pkg, the RTL and glmf_peak_checker.
`timescale 1ns / 1ps

module grid_local_maximum_finder_tb;
    import glmf_pkg::*;

    localparam int MAX_ROWS      = 1024;
    localparam int MAX_COLUMNS   = 1024;
    localparam int RANDOM_CELLS  = 300;
    localparam int SAT_CELLS     = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;

    // unmapped register indexes, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [VALUE_W-1:0] CELL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] CELL_MAX = 32'sh7fff_ffff;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_t;

    logic                      aclk;
    logic                      aresetn       = 1'b0;
    logic                      cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index     = '0;
    logic [CFG_W-1:0]          cfg_wr_data   = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_cell_value  = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic [IDX_W-1:0]          m_peak_row;
    logic [IDX_W-1:0]          m_peak_column;
    logic                      m_last_of_run;

    int fail_count;
    int pending;
    int hold_requests = 0;
    int burst_left    = 0;

    logic signed [VALUE_W-1:0] grid_3x3 [9];

    grid_local_maximum_finder #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_value  (s_cell_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak_row    (m_peak_row),
        .m_peak_column (m_peak_column),
        .m_last_of_run (m_last_of_run)
    );

    glmf_peak_checker #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) peak_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_value  (s_cell_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak_row    (m_peak_row),
        .m_peak_column (m_peak_column),
        .m_last_of_run (m_last_of_run),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        #5_000_000;
        $display("grid_local_maximum_finder_tb failed");
        $finish;
    end

    // Receiver: random readiness patterns, plus a long hold-off on request
    initial begin : receiver
        rx_mode_t mode;
        int       span;
        int       hold_left;
        int       served;
        span      = 0;
        hold_left = 0;
        served    = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge aclk);
            if (hold_requests != served) begin
                served    = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(10, 120);
                end
                span--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                    default:   m_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] random_cell();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return int'($urandom_range(0, 6)) - 3;
            2:       return $urandom_range(0, 1) ? CELL_MAX : CELL_MIN;
            default: return CELL_MAX - int'($urandom_range(0, 2));
        endcase
    endfunction

    // Offer one cell and return at the edge of its transfer
    task automatic send_cell(input logic signed [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_cell_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering until every predicted peak has come out, then let the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_shape(input int rows, input int cols);
        write_reg(REG_ROW_COUNT, CFG_W'(rows));
        write_reg(REG_COLUMN_COUNT, CFG_W'(cols));
    endtask

    initial begin : stimulus
        int                        rows;
        int                        cols;
        int                        n;
        int                        shape;
        int                        random_sent;
        logic signed [VALUE_W-1:0] flat;
        grid_3x3 = '{CELL_MAX, CELL_MAX, 0,
                     -1,       CELL_MIN, 5,
                     CELL_MAX, CELL_MIN, 5};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset shape is 1x1: every cell is its own peak
        send_cell(CELL_MIN);
        send_cell(CELL_MAX);
        send_cell(-1);
        drain_results();

        // zero counts behave as one
        set_shape(0, 0);
        send_cell(0);
        drain_results();

        // 3x3 with corners, edges, center, ties and extremes
        set_shape(3, 3);
        for (int i = 0; i < 5; i++) send_cell(grid_3x3[i]);
        drain_results();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        for (int i = 5; i < 9; i++) send_cell(grid_3x3[i]);
        for (int i = 8; i > 5; i--) send_cell(grid_3x3[i]);
        drain_results();
        // rewrite mid-frame: partial frame is dropped
        write_reg(REG_COLUMN_COUNT, CFG_W'(3));
        for (int i = 0; i < 9; i++) send_cell(grid_3x3[i]);
        drain_results();

        // oversized counts saturate; one column so each cell is a row
        set_shape(2047, 1);
        for (int i = 0; i < SAT_CELLS; i++) send_cell(random_cell());
        drain_results();
        set_shape(1, 2047);
        for (int i = 0; i < SAT_CELLS; i++) send_cell(random_cell());
        drain_results();

        // flat frame makes every cell a peak; receiver holds off so the queue fills
        set_shape(4, 8);
        hold_requests <= hold_requests + 1;
        flat = $urandom;
        for (int i = 0; i < 32; i++) send_cell(flat);
        drain_results();

        random_sent = 0;
        while (random_sent < RANDOM_CELLS) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                rows = $urandom_range(1, 2);
                cols = $urandom_range(20, 64);
            end else if (shape == 1) begin
                rows = $urandom_range(20, 64);
                cols = $urandom_range(1, 2);
            end else begin
                rows = $urandom_range(1, 6);
                cols = $urandom_range(1, 8);
            end
            set_shape(rows, cols);
            n = rows * cols * $urandom_range(1, 3);
            if ($urandom_range(0, 2) == 0) n += $urandom_range(0, rows * cols - 1);
            for (int i = 0; i < n && random_sent < RANDOM_CELLS; i++) begin
                if ($urandom_range(0, 63) == 0) drain_results();
                send_cell(random_cell());
                random_sent++;
            end
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("grid_local_maximum_finder_tb passed");
        end else begin
            $display("grid_local_maximum_finder_tb failed");
        end
        $finish;
    end

endmodule
